### sv/tccw_pkg.sv
`timescale 1ns / 1ps

package tccw_pkg;

    // grid geometry
    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int CELLS  = COLS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);

    // field widths
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int BYTE_W = 8;

    // character codes
    localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [BYTE_W-1:0] SPACE_CODE   = 8'd32;

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_BACK  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd              cmd;
        logic [BYTE_W-1:0] char_code;
        logic [BYTE_W-1:0] color;
        logic [COL_W-1:0]  read_col;
        logic [ROW_W-1:0]  read_row;
    } t_in_item;

    typedef struct packed {
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic [BYTE_W-1:0] cell_char;
        logic [BYTE_W-1:0] cell_color;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic latch_in;
        logic exec;
        logic clr_step;
        logic load_out;
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_clear;
        logic clr_last;
    } t_dp_status;

endpackage

### sv/tccw_ctrl.sv
`timescale 1ns / 1ps

module tccw_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  tccw_pkg::t_dp_status i_status,
    output tccw_pkg::t_ctl_cmd   o_cmd
);
    import tccw_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CLEAR,
        ST_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    // next state and command decode
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_status.is_clear ? ST_CLEAR : ST_DONE;
            end
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### sv/tccw_datapath.sv
`timescale 1ns / 1ps

module tccw_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tccw_pkg::t_in_item   i_in,
    input  tccw_pkg::t_ctl_cmd   i_cmd,
    output tccw_pkg::t_dp_status o_status,
    output tccw_pkg::t_out_item  o_out
);
    import tccw_pkg::*;

    localparam logic [COL_W-1:0]  COLS_C  = COL_W'(COLS);
    localparam logic [ROW_W-1:0]  ROWS_C  = ROW_W'(ROWS);
    localparam logic [ADDR_W-1:0] LAST_A  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COLS_A  = ADDR_W'(COLS);

    function automatic logic [ADDR_W-1:0] f_addr(input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] col);
        return ADDR_W'(row) * COLS_A + ADDR_W'(col);
    endfunction

    t_in_item          r_in;
    t_out_item         r_out;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_rd_ok;
    logic [15:0]       r_rd_data;
    logic [15:0]       mem [CELLS];

    logic [COL_W-1:0]  wr_col;
    logic [ROW_W-1:0]  wr_row;
    logic [BYTE_W-1:0] wr_char;
    logic              wr_en;
    logic              rd_ok;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_in <= i_in;
        end
    end

    // cursor update and target cell for the current transaction
    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        wr_col  = r_col;
        wr_row  = r_row;
        wr_char = SPACE_CODE;
        wr_en   = 1'b0;
        rd_ok   = (r_in.read_col < COLS_C) && (r_in.read_row < ROWS_C);
        case (r_in.cmd)
            CMD_PUT: begin
                if (r_in.char_code == NEWLINE_CODE) begin
                    n_col = '0;
                    if (r_row < ROWS_C) begin
                        n_row = r_row + ROW_W'(1);
                    end
                end else begin
                    if (r_col >= COLS_C) begin
                        wr_col = '0;
                        wr_row = r_row + ROW_W'(1);
                    end
                    if (wr_row >= ROWS_C) begin
                        wr_row = ROWS_C - ROW_W'(1);
                    end
                    wr_char = r_in.char_code;
                    wr_en   = 1'b1;
                    n_col   = wr_col + COL_W'(1);
                    n_row   = wr_row;
                end
            end
            CMD_BACK: begin
                if (!(r_col == '0 && r_row == '0)) begin
                    if (r_col == '0) begin
                        wr_row = r_row - ROW_W'(1);
                        wr_col = COLS_C - COL_W'(1);
                    end else begin
                        wr_col = r_col - COL_W'(1);
                    end
                    n_col = wr_col;
                    n_row = wr_row;
                    // blank only when it lands on the grid
                    wr_en = (wr_col < COLS_C) && (wr_row < ROWS_C);
                end
            end
            CMD_CLEAR: begin
                n_col = '0;
                n_row = '0;
            end
            CMD_READ: begin
                n_col = r_col;
            end
            default: begin
                n_col = r_col;
            end
        endcase
    end

    // cursor registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.exec) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // clear sweep address
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    // single write port shared by the sweep and the cursor writes
    assign mem_we    = (i_cmd.exec && wr_en) || i_cmd.clr_step;
    assign mem_waddr = i_cmd.clr_step ? r_clr_addr : f_addr(wr_row, wr_col);
    assign mem_wdata = i_cmd.clr_step ? {r_in.color, SPACE_CODE} : {r_in.color, wr_char};

    // cell memory, character in the low byte
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.exec && r_in.cmd == CMD_READ && rd_ok) begin
            r_rd_data <= mem[f_addr(r_in.read_row, r_in.read_col)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_rd_ok <= (r_in.cmd == CMD_READ) && rd_ok;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.cursor_col <= r_col;
            r_out.cursor_row <= r_row;
            r_out.cell_char  <= r_rd_ok ? r_rd_data[BYTE_W-1:0] : '0;
            r_out.cell_color <= r_rd_ok ? r_rd_data[15:BYTE_W] : '0;
        end
    end

    assign o_status.is_clear = (r_in.cmd == CMD_CLEAR);
    assign o_status.clr_last = (r_clr_addr == LAST_A);
    assign o_out             = r_out;

endmodule

### sv/text_console_cell_writer.sv
`timescale 1ns / 1ps
// a put, backspace or read result passes the accept, execute and done states before it is registered as valid
// a new transaction is taken only in idle, once the accept, execute, load sequence of the last one is through
// clear adds a sweep that blanks all 2000 cells, one cell a cycle through the single write port
// a new transaction is taken while the previous result waits in the output register
// reset homes the cursor and clears handshake state; the cell memory is not cleared
module text_console_cell_writer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tccw_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tccw_pkg::t_out_item o_out
);
    import tccw_pkg::*;

    t_ctl_cmd   ctl_cmd;
    t_dp_status dp_status;

    tccw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (dp_status),
        .o_cmd       (ctl_cmd)
    );

    tccw_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cmd    (ctl_cmd),
        .o_status (dp_status),
        .o_out    (o_out)
    );

    // one transaction in flight: the block is busy right after taking one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken twice in a row");

    // reported cursor stays within the grid plus the full-row and past-last-row marks
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.cursor_col <= COL_W'(COLS) && o_out.cursor_row <= ROW_W'(ROWS)))
        else $error("cursor out of range");

    // a fresh result only appears while the input side is busy with its transaction
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without transaction");

endmodule
